// ===== design/tdsdf_pkg.sv =====
`timescale 1ns / 1ps
package tdsdf_pkg;

  localparam int HEADER_BYTES = 8;
  localparam int WIN_LEN      = HEADER_BYTES + 1;
  localparam int FILL_W       = $clog2(WIN_LEN + 1);
  localparam int LEN_W        = 16;

  localparam logic [7:0] HDR_TYPE_BYTE = 8'h0F;
  localparam logic [7:0] TAIL_A        = 8'h21;
  localparam logic [7:0] TAIL_B        = 8'h61;
  localparam logic [7:0] TAIL_C        = 8'h00;
  localparam logic [7:0] STATUS_MORE   = 8'h00;
  localparam logic [7:0] STATUS_EOM    = 8'h01;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd8192;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 16'd8;

  typedef enum logic [0:0] {
    CFG_MAX_LEN = 1'b0,
    CFG_MIN_LEN = 1'b1
  } cfg_index_t;

  typedef logic [7:0] byte_t;

endpackage

// ===== design/tds_packet_deframer_top.sv =====
`timescale 1ns / 1ps
// The result of each input transfer is registered into the output register.
// Throughput: one byte per cycle; the input stays ready while the output register
// is empty or being drained in the same cycle.
// Reset (rst, synchronous): clears hunt/payload control, output valid and both
// length registers (max_len 8192, min_len 8); header window contents are not reset.
module tds_packet_deframer_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // [7:0] data_byte
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [7:0]               m_tdata,   // [7:0] payload_byte
  output logic [1:0]               m_tuser,   // [0] payload_valid, [1] message_start
  output logic                     m_tlast,   // message_end
  input  logic                     cfg_we,
  input  tdsdf_pkg::cfg_index_t    cfg_index,
  input  logic [tdsdf_pkg::LEN_W-1:0] cfg_wdata
);
  import tdsdf_pkg::*;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_LEN - 1);
  localparam logic [LEN_W-1:0]  HDR_LEN   = LEN_W'(HEADER_BYTES);
  localparam logic [LEN_W-1:0]  WIN_LEN_L = LEN_W'(WIN_LEN);

  byte_t             win [WIN_LEN];
  byte_t             win_next [WIN_LEN];
  logic [FILL_W-1:0] fill, fill_next;
  logic              in_payload, in_payload_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              final_fragment, final_fragment_next;
  logic              message_open, message_open_next;
  logic [LEN_W-1:0]  max_len, min_len;

  logic              acc;
  logic              res_valid, res_pv, res_start, res_end;
  byte_t             res_byte;
  logic [LEN_W-1:0]  pkt_len, bl_dec;
  logic              hdr_ok, status;

  assign s_tready = !m_tvalid || m_tready;
  assign acc      = s_tvalid && s_tready;

  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_next[i] = win[i+1];
    end
    win_next[WIN_LEN-1] = s_tdata;
  end

  assign pkt_len = {win_next[2], win_next[3]};
  assign bl_dec  = bytes_left - LEN_W'(1);
  assign status  = win_next[1][0];
  assign hdr_ok  = (win_next[0] == HDR_TYPE_BYTE)
                && (win_next[1] == STATUS_MORE || win_next[1] == STATUS_EOM)
                && (win_next[WIN_LEN-1] == TAIL_A || win_next[WIN_LEN-1] == TAIL_B
                    || win_next[WIN_LEN-1] == TAIL_C)
                && (pkt_len >= HDR_LEN)
                && (pkt_len >= min_len) && (pkt_len <= max_len);

  always_comb begin
    fill_next           = fill;
    in_payload_next     = in_payload;
    bytes_left_next     = bytes_left;
    final_fragment_next = final_fragment;
    message_open_next   = message_open;
    res_valid           = 1'b0;
    res_byte            = s_tdata;
    res_pv              = 1'b1;
    res_start           = 1'b0;
    res_end             = 1'b0;
    if (in_payload) begin
      bytes_left_next = bl_dec;
      res_valid       = 1'b1;
      if (bl_dec == '0) begin
        in_payload_next = 1'b0;
        fill_next       = '0;
        if (final_fragment) begin
          res_end           = 1'b1;
          message_open_next = 1'b0;
        end
      end
    end else begin
      fill_next = (fill >= FILL_LAST) ? FILL_FULL : fill + FILL_W'(1);
      if (fill_next == FILL_FULL && hdr_ok) begin
        res_start = !message_open;
        if (pkt_len == HDR_LEN) begin
          // empty packet: keep the trailing byte as the first byte of the next hunt
          fill_next = FILL_W'(1);
          if (status) begin
            message_open_next = 1'b0;
            res_valid         = 1'b1;
            res_byte          = '0;
            res_pv            = 1'b0;
            res_end           = 1'b1;
          end
        end else begin
          message_open_next   = 1'b1;
          bytes_left_next     = pkt_len - WIN_LEN_L;
          final_fragment_next = status;
          fill_next           = '0;
          res_valid           = 1'b1;
          if (pkt_len == WIN_LEN_L) begin
            if (status) begin
              res_end           = 1'b1;
              message_open_next = 1'b0;
            end
          end else begin
            in_payload_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      in_payload     <= 1'b0;
      bytes_left     <= '0;
      final_fragment <= 1'b0;
      message_open   <= 1'b0;
      m_tvalid       <= 1'b0;
      max_len        <= MAX_LEN_RESET;
      min_len        <= MIN_LEN_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MAX_LEN: max_len <= cfg_wdata;
          CFG_MIN_LEN: min_len <= cfg_wdata;
          default:     ;
        endcase
      end
      if (acc) begin
        fill           <= fill_next;
        in_payload     <= in_payload_next;
        bytes_left     <= bytes_left_next;
        final_fragment <= final_fragment_next;
        message_open   <= message_open_next;
        m_tvalid       <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) begin
      m_tdata <= res_byte;
      m_tuser <= {res_start, res_pv};
      m_tlast <= res_end;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("window fill out of range");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> bytes_left != '0)
    else $error("payload active with zero bytes left");

  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> m_tlast)
    else $error("end marker without message end");

  a_payload_no_fill: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> fill == '0)
    else $error("window not empty during payload");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tdsdf_pkg::*;

  typedef struct packed {
    byte_t pbyte;
    logic  pvalid;
    logic  mstart;
    logic  mend;
  } deframe_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = 8'h00;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;
  logic              cfg_we = 1'b0;
  cfg_index_t        cfg_index = CFG_MAX_LEN;
  logic [LEN_W-1:0]  cfg_wdata = '0;

  // deframer state as seen by the scoreboard
  byte_t             win [WIN_LEN];
  int                fill = 0;
  logic              in_pay = 1'b0;
  logic [LEN_W-1:0]  left = '0;
  logic              fin = 1'b0;
  logic              mopen = 1'b0;
  logic [LEN_W-1:0]  cfg_max = MAX_LEN_RESET;
  logic [LEN_W-1:0]  cfg_min = MIN_LEN_RESET;

  deframe_result_t   expected_payload_q [$];
  int                errors = 0;
  int                n_sent = 0;
  int                burst_left = 0;
  logic              gaps_on = 1'b1;
  int                ready_pct = 100;
  int                mode_left = 0;

  tds_packet_deframer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic header_match(input logic [LEN_W-1:0] plen);
    if (win[0] != HDR_TYPE_BYTE) return 1'b0;
    if (win[1] != STATUS_MORE && win[1] != STATUS_EOM) return 1'b0;
    if (win[8] != TAIL_A && win[8] != TAIL_B && win[8] != TAIL_C) return 1'b0;
    if (plen < HEADER_BYTES) return 1'b0;
    if (plen < cfg_min || plen > cfg_max) return 1'b0;
    return 1'b1;
  endfunction

  task automatic deframe_byte(input byte_t b);
    deframe_result_t r;
    logic [LEN_W-1:0] plen;
    logic st;
    logic first_res;
    if (in_pay) begin
      left = left - LEN_W'(1);
      r.pbyte = b;
      r.pvalid = 1'b1;
      r.mstart = 1'b0;
      r.mend = 1'b0;
      if (left == 0) begin
        in_pay = 1'b0;
        fill = 0;
        if (fin) begin
          r.mend = 1'b1;
          mopen = 1'b0;
        end
      end
      expected_payload_q.push_back(r);
      return;
    end
    if (fill >= WIN_LEN) begin
      for (int i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
      win[WIN_LEN-1] = b;
    end else begin
      win[fill] = b;
      fill++;
    end
    if (fill < WIN_LEN) return;
    plen = {win[2], win[3]};
    if (!header_match(plen)) return;
    st = win[1][0];
    first_res = ~mopen;
    if (plen == HEADER_BYTES) begin
      win[0] = win[8];
      fill = 1;
      if (!st) return;
      mopen = 1'b0;
      r.pbyte = '0;
      r.pvalid = 1'b0;
      r.mstart = first_res;
      r.mend = 1'b1;
      expected_payload_q.push_back(r);
      return;
    end
    mopen = 1'b1;
    left = plen - LEN_W'(WIN_LEN);
    fin = st;
    fill = 0;
    r.pbyte = win[8];
    r.pvalid = 1'b1;
    r.mstart = first_res;
    r.mend = 1'b0;
    if (left == 0) begin
      if (st) begin
        r.mend = 1'b1;
        mopen = 1'b0;
      end
    end else begin
      in_pay = 1'b1;
    end
    expected_payload_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < 40)
      $display("%0t: mismatch %s: got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    deframe_result_t w;
    if (expected_payload_q.size() == 0) begin
      report_mismatch("unexpected transfer", 16'(m_tdata), 16'h0000);
      return;
    end
    w = expected_payload_q.pop_front();
    if (m_tdata !== w.pbyte)
      report_mismatch("payload_byte", 16'(m_tdata), 16'(w.pbyte));
    if (m_tuser[0] !== w.pvalid)
      report_mismatch("payload_valid", 16'(m_tuser[0]), 16'(w.pvalid));
    if (m_tuser[1] !== w.mstart)
      report_mismatch("message_start", 16'(m_tuser[1]), 16'(w.mstart));
    if (m_tlast !== w.mend)
      report_mismatch("message_end", 16'(m_tlast), 16'(w.mend));
  endtask

  // output check first: an input accepted at this edge yields its result later
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid === 1'b1 && m_tready === 1'b1) check_result();
      if (s_tvalid === 1'b1 && s_tready === 1'b1) deframe_byte(s_tdata);
    end
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 75;
        2: ready_pct = 50;
        default: ready_pct = 25;
      endcase
    end
    mode_left--;
    m_tready <= ($urandom_range(1, 100) <= ready_pct);
  end

  task automatic send_byte(input byte_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_stream();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_payload_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [LEN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_LEN) cfg_max = val;
    else cfg_min = val;
    @(posedge clk);
  endtask

  task automatic send_packet(input byte_t ty, input byte_t status, input logic [15:0] plen,
                             input byte_t first, input int body);
    send_byte(ty);
    send_byte(status);
    send_byte(plen[15:8]);
    send_byte(plen[7:0]);
    repeat (4) send_byte(8'($urandom));
    send_byte(first);
    repeat (body) send_byte(8'($urandom));
  endtask

  function automatic byte_t pick_tail();
    case ($urandom_range(0, 2))
      0: return TAIL_A;
      1: return TAIL_B;
      default: return TAIL_C;
    endcase
  endfunction

  task automatic send_random_packet(input int lo, input int hi);
    byte_t ty, st, first;
    logic [15:0] plen;
    int body, kind;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      return;
    end
    ty = HDR_TYPE_BYTE;
    st = $urandom_range(0, 1) ? STATUS_EOM : STATUS_MORE;
    plen = 16'($urandom_range(lo, hi));
    first = pick_tail();
    body = (plen > HEADER_BYTES + 1) ? plen - WIN_LEN : 0;
    if (kind < 22) begin
      body = $urandom_range(0, 8);
      case ($urandom_range(0, 3))
        0: do ty = 8'($urandom); while (ty == HDR_TYPE_BYTE);
        1: st = 8'($urandom_range(2, 255));
        2: do first = 8'($urandom); while (first == TAIL_A || first == TAIL_B || first == TAIL_C);
        default: plen = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'hFFFF;
      endcase
    end
    send_packet(ty, st, plen, first, body);
  endtask

  task automatic random_traffic(input int nbytes, input int lo, input int hi);
    int stop;
    stop = n_sent + nbytes;
    while (n_sent < stop) send_random_packet(lo, hi);
    drain_stream();
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty final packet: end marker only
    send_packet(HDR_TYPE_BYTE, STATUS_EOM, 16'd8, TAIL_B, 0);
    // empty non-final packet: nothing comes out
    send_packet(HDR_TYPE_BYTE, STATUS_MORE, 16'd8, TAIL_C, 0);
    // single payload byte, taken from the header's ninth byte
    send_packet(HDR_TYPE_BYTE, STATUS_EOM, 16'd9, TAIL_A, 0);
    drain_stream();
  endtask

  task automatic test_full_length();
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    write_reg(CFG_MIN_LEN, 16'hFFFF);
    gaps_on = 1'b0;
    // below the minimum: rejected
    send_packet(HDR_TYPE_BYTE, STATUS_MORE, 16'd9000, TAIL_A, 20);
    drain_stream();
    write_reg(CFG_MIN_LEN, 16'd100);
    send_packet(HDR_TYPE_BYTE, STATUS_EOM, 16'd100, TAIL_C, 100 - WIN_LEN);
    gaps_on = 1'b1;
    drain_stream();
  endtask

  task automatic test_min_above_max();
    write_reg(CFG_MIN_LEN, 16'd100);
    write_reg(CFG_MAX_LEN, 16'd50);
    repeat (5)
      send_packet(HDR_TYPE_BYTE, STATUS_EOM, 16'($urandom_range(40, 110)), pick_tail(), 4);
    drain_stream();
  endtask

  task automatic test_config_phases();
    write_reg(CFG_MIN_LEN, 16'd12);
    write_reg(CFG_MAX_LEN, 16'd20);
    random_traffic(80, 6, 24);
    write_reg(CFG_MIN_LEN, 16'd8);
    write_reg(CFG_MAX_LEN, 16'd8);
    random_traffic(60, 8, 9);
    write_reg(CFG_MAX_LEN, 16'd300);
    random_traffic(80, 8, 60);
  endtask

  task automatic finish_run();
    int guard;
    s_tvalid <= 1'b0;
    guard = 0;
    while (expected_payload_q.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_payload_q.size() != 0)
      report_mismatch("results never arrived", 16'(expected_payload_q.size()), 16'h0000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    random_traffic(120, 8, 40);
    test_full_length();
    test_min_above_max();
    test_config_phases();
    finish_run();
    if (errors == 0) begin
      $display("** tds_packet_deframer_top: PASSED **");
    end else begin
      $display("** tds_packet_deframer_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("** tds_packet_deframer_top: FAILED **");
    $finish;
  end

endmodule
